FILE: src/spq_pkg.sv
// Shared constants, types and status codes for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH      = 32;
  localparam int TAG_WIDTH  = 32;
  localparam int PRIO_WIDTH = 8;

  // Fixed widths of the channel fields.
  localparam int PAYLOAD_W = 32;
  localparam int PRIO_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;

  // Live-entry counter must hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [TAG_WIDTH-1:0]  tag_t;
  typedef logic [PRIO_WIDTH-1:0] prio_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // One stored entry, as handed between neighboring cells.
  typedef struct packed {
    tag_t  tag;
    prio_t prio;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic  ins_en;
    logic  rem_en;
    tag_t  tag;
    prio_t prio;
  } cell_cmd_t;

endpackage

FILE: src/spq_if.sv
// Valid/ready channel interfaces for the queue's request and response sides.
interface spq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [spq_pkg::PAYLOAD_W-1:0] payload;
  logic [spq_pkg::PRIO_W-1:0]    priority_req;

  modport source (output valid, output mode, output payload, output priority_req,
                  input ready);
  modport sink   (input valid, input mode, input payload, input priority_req,
                  output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::PAYLOAD_W-1:0] out_payload;
  logic [spq_pkg::PRIO_W-1:0]    out_priority;
  logic [spq_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output out_payload,
                  output out_priority, output count, input ready);
  modport sink   (input valid, input status, input out_payload,
                  input out_priority, input count, output ready);
endinterface

FILE: src/spq_cell.sv
// One slot of the sorted shift register: holds an entry, shifts or loads.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               live,       // slot holds a live entry
  input  logic               prev_place, // left neighbor opens or shifts
  input  spq_pkg::entry_t    prev_ent,
  input  spq_pkg::entry_t    next_ent,
  output logic               place,
  output spq_pkg::entry_t    ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  // Strictly greater keeps equal priorities in arrival order.
  assign place = !live || (ent_r.prio > cmd.prio);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins_en && place) begin
      if (prev_place) begin
        ent_nxt = prev_ent;
      end else begin
        ent_nxt.tag  = cmd.tag;
        ent_nxt.prio = cmd.prio;
      end
    end else if (cmd.rem_en) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

FILE: src/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, live count, result register.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------
//  in_chan  | in  | valid/ready      | mode, payload, priority_req
//  out_chan | out | valid/ready      | status, out_payload, out_priority, count
//
// One transaction per cycle while the output is not stalled: every cell compares
// against the new priority in parallel and shifts or loads in the same edge, and
// the result appears in the output register in the cycle after acceptance.
// Reset (rst_n low, synchronous) clears the live count and the output valid;
// cell contents are not reset, slots past the count are never read.
// A stalled result holds the output register; a new transaction is taken in the
// cycle the pending result is taken.
module sorted_priority_queue_top (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_chan,
  spq_out_if.source        out_chan
);

  localparam int D = spq_pkg::DEPTH;

  spq_pkg::cnt_t cnt_r;
  spq_pkg::cnt_t cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [spq_pkg::STATUS_W-1:0]  status_r,  status_nxt;
  logic [spq_pkg::PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic [spq_pkg::PRIO_W-1:0]    prio_r,    prio_nxt;
  logic [spq_pkg::COUNT_W-1:0]   count_r,   count_nxt;

  logic accept;
  logic full;
  logic empty;
  logic is_remove;

  spq_pkg::cell_cmd_t cmd;
  spq_pkg::entry_t    ent   [D];
  logic               place [D];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (cnt_r == spq_pkg::cnt_t'(D));
  assign empty         = (cnt_r == '0);
  assign is_remove     = (in_chan.mode == spq_pkg::MODE_REMOVE);

  // Broadcast command; fields cast to the stored widths.
  always_comb begin
    cmd.ins_en = accept && !is_remove && !full;
    cmd.rem_en = accept &&  is_remove && !empty;
    cmd.tag    = spq_pkg::tag_t'(in_chan.payload);
    cmd.prio   = spq_pkg::prio_t'(in_chan.priority_req);
  end

  // Cell chain: slot 0 is the head. Live slots form a prefix given by the count.
  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .live       (cnt_r > spq_pkg::cnt_t'(i)),
      .prev_place ((i == 0) ? 1'b0 : place[(i == 0) ? 0 : i - 1]),
      .prev_ent   (ent[(i == 0) ? 0 : i - 1]),
      .next_ent   (ent[(i == D - 1) ? D - 1 : i + 1]),
      .place      (place[i]),
      .ent        (ent[i])
    );
  end

  // Live count and result formation.
  always_comb begin
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    payload_nxt = payload_r;
    prio_nxt    = prio_r;
    count_nxt   = count_r;
    if (cmd.ins_en) begin
      cnt_nxt = cnt_r + spq_pkg::cnt_t'(1);
    end else if (cmd.rem_en) begin
      cnt_nxt = cnt_r - spq_pkg::cnt_t'(1);
    end
    if (accept) begin
      payload_nxt = '0;
      prio_nxt    = '0;
      if (is_remove) begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          status_nxt  = spq_pkg::ST_OK;
          payload_nxt = spq_pkg::PAYLOAD_W'(ent[0].tag);
          prio_nxt    = spq_pkg::PRIO_W'(ent[0].prio);
        end
      end else begin
        status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end
      count_nxt = spq_pkg::COUNT_W'(cnt_nxt);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers need no reset.
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    payload_r <= payload_nxt;
    prio_r    <= prio_nxt;
    count_r   <= count_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.out_payload  = payload_r;
  assign out_chan.out_priority = prio_r;
  assign out_chan.count        = count_r;

  // Count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= spq_pkg::cnt_t'(D))
    else $error("live count above depth");

  // A rejected insert leaves the count at depth.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_remove && full) |=> (cnt_r == spq_pkg::cnt_t'(D)))
    else $error("rejected insert changed count");

  // Head stays sorted ahead of its neighbor.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= spq_pkg::cnt_t'(2)) |-> (ent[0].prio <= ent[1].prio))
    else $error("head out of order");

  // A successful remove drops the count by one.
  a_rem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_en |=> (cnt_r == $past(cnt_r) - spq_pkg::cnt_t'(1)))
    else $error("remove count mismatch");

endmodule
